// ----- src/fir_convolution_wet_dry_mix_top_macros.svh -----
// Assertion macros for the FIR convolver checker.
// Needs nothing else; included by the checker file only.
`ifndef FIR_CONVOLUTION_WET_DRY_MIX_TOP_MACROS_SVH
`define FIR_CONVOLUTION_WET_DRY_MIX_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FCWDM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FCWDM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/fcwdm_pkg.sv -----
// Shared types, widths and codes of the FIR convolver with wet/dry mix.
// No dependencies; compile first.
package fcwdm_pkg;

    localparam int SAMPLE_W     = 24;
    localparam int TAP_W        = 18;
    localparam int TAP_DEPTH    = 4096;
    localparam int TAP_AW       = 12;
    localparam int TAP_COUNT_W  = 13;
    localparam int MIX_W        = 17;
    localparam int ACC_W        = SAMPLE_W + TAP_W + TAP_AW;
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = 17;
    localparam int RING_DEPTH_DEF = 4096;

    localparam logic [MIX_W-1:0] MIX_ONE = MIX_W'(65536);

    // Item opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_WET_MIX   = CFG_IDX_W'(1);

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [TAP_W-1:0]    tap_t;
    typedef logic signed [ACC_W-1:0]    acc_t;

    // Control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clear;
        logic valid;
    } mac_ctl_t;

endpackage

// ----- src/fcwdm_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module fcwdm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/fcwdm_mac.sv -----
// Shared multiply-accumulate unit: registered product, then wide accumulator.
// Depends on fcwdm_pkg.
module fcwdm_mac (
    input  logic                clk,
    input  logic                rst_n,
    input  fcwdm_pkg::mac_ctl_t ctl,
    input  fcwdm_pkg::sample_t  smp,
    input  fcwdm_pkg::tap_t     coef,
    output fcwdm_pkg::acc_t     acc,
    output logic                busy
);
    import fcwdm_pkg::*;

    localparam int PROD_W = SAMPLE_W + TAP_W;

    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic                     prod_vld_reg, prod_vld_next;
    acc_t                     acc_reg, acc_next;

    always_comb begin
        prod_next     = prod_reg;
        prod_vld_next = ctl.valid;
        acc_next      = acc_reg;
        if (ctl.valid) begin
            prod_next = PROD_W'(smp) * PROD_W'(coef);
        end
        if (ctl.clear) begin
            acc_next = '0;
        end else if (prod_vld_reg) begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            prod_vld_reg <= 1'b0;
        end else begin
            prod_vld_reg <= prod_vld_next;
        end
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign acc  = acc_reg;
    assign busy = prod_vld_reg;

endmodule

// ----- src/fir_convolution_wet_dry_mix_top.sv -----
// Top level of the direct-form FIR convolver with dry/wet mix.
// Depends on fcwdm_pkg, fcwdm_ram and fcwdm_mac.
//
//  Channel  Direction  Handshake            Payload
//  s_       in         s_valid / s_ready    s_op, s_sample_in, s_tap_index, s_tap_value
//  m_       out        m_valid / m_ready    m_sample_out
//  cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A coefficient load is written on transfer and leaves s_ready high. A sample
// steps through RUN, DRAIN, WET, MUL and OUT before s_ready returns; RUN issues
// N taps, N = min(tap_count, 4096, RING_DEPTH), masking those past the samples
// that have arrived since reset; the single shared multiply-accumulate and the one read
// port of each memory take one tap a cycle.
// With N zero a sample goes straight to OUT (pass-through).
// Reset is synchronous, active low; the history ring needs no clearing pass,
// a fill count masks entries not yet written since reset.
// A finished result waits in the output register while the next item is taken;
// the sequencer only stalls at its last step if that register is still full.
module fir_convolution_wet_dry_mix_top #(
    parameter int RING_DEPTH = fcwdm_pkg::RING_DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input items
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_op,
    input  fcwdm_pkg::sample_t                  s_sample_in,
    input  logic [fcwdm_pkg::TAP_AW-1:0]        s_tap_index,
    input  fcwdm_pkg::tap_t                     s_tap_value,
    // results
    output logic                                m_valid,
    input  logic                                m_ready,
    output fcwdm_pkg::sample_t                  m_sample_out,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fcwdm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fcwdm_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import fcwdm_pkg::*;

    localparam int RING_AW   = $clog2(RING_DEPTH);
    localparam int FILL_W    = $clog2(RING_DEPTH + 1);
    localparam int TAP_LIMIT = (RING_DEPTH < TAP_DEPTH) ? RING_DEPTH : TAP_DEPTH;
    localparam int WET_W     = ACC_W - 17;
    localparam int PDRY_W    = SAMPLE_W + MIX_W + 1;
    localparam int PWET_W    = WET_W + MIX_W + 1;
    localparam int SUM_W     = PWET_W + 1;

    localparam logic [TAP_COUNT_W-1:0] TAP_LIMIT_C = TAP_COUNT_W'(TAP_LIMIT);
    localparam logic [RING_AW-1:0]     RING_LAST   = RING_AW'(RING_DEPTH - 1);
    localparam logic [FILL_W-1:0]      FILL_FULL   = FILL_W'(RING_DEPTH);
    localparam logic [ACC_W-1:0]       ACC_ROUND   = ACC_W'(65536);
    localparam logic [SUM_W-1:0]       MIX_ROUND   = SUM_W'(32768);

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RUN   = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_WET   = 3'd3;
    localparam logic [2:0] ST_MUL   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]               state_reg, state_next;
    logic [RING_AW-1:0]       wp_reg, wp_next;
    logic [RING_AW-1:0]       rp_reg, rp_next;
    logic [FILL_W-1:0]        fill_reg, fill_next;
    logic [TAP_COUNT_W-1:0]   taps_reg, taps_next;
    logic [TAP_COUNT_W-1:0]   j_reg, j_next;
    logic                     bypass_reg, bypass_next;
    logic                     rd_vld_reg, rd_vld_next;
    logic                     rd_ok_reg, rd_ok_next;
    sample_t                  dry_reg, dry_next;
    logic signed [WET_W-1:0]  wet_reg, wet_next;
    logic signed [PDRY_W-1:0] pdry_reg, pdry_next;
    logic signed [PWET_W-1:0] pwet_reg, pwet_next;
    logic                     m_valid_reg, m_valid_next;
    sample_t                  m_data_reg, m_data_next;
    logic [TAP_COUNT_W-1:0]   tap_count_reg, tap_count_next;
    logic [MIX_W-1:0]         wet_mix_reg, wet_mix_next;

    logic                     s_xfer;
    logic [TAP_COUNT_W-1:0]   taps_eff;
    logic [MIX_W-1:0]         mix_eff;
    logic signed [SUM_W-1:0]  mix_sum;
    logic signed [SUM_W-1:0]  mix_sh;
    logic                     mix_fits;
    sample_t                  mix_sat;

    logic                     ring_we;
    logic                     rd_en;
    sample_t                  hist_rdata;
    tap_t                     tap_rdata;
    mac_ctl_t                 mac_ctl;
    acc_t                     mac_acc;
    logic                     mac_busy;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_xfer    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_sample_out = m_data_reg;

    // Limit the tap count to what both the coefficient store and the ring hold
    assign taps_eff = (tap_count_reg > TAP_LIMIT_C) ? TAP_LIMIT_C : tap_count_reg;
    // Clamp mix to one
    assign mix_eff  = (wet_mix_reg > MIX_ONE) ? MIX_ONE : wet_mix_reg;

    // Final mix: round, floor-shift by 16, saturate to the sample width
    always_comb begin
        mix_sum  = SUM_W'(pdry_reg) + SUM_W'(pwet_reg) + $signed(MIX_ROUND);
        mix_sh   = mix_sum >>> 16;
        mix_fits = (&mix_sh[SUM_W-1:SAMPLE_W-1]) || !(|mix_sh[SUM_W-1:SAMPLE_W-1]);
        if (mix_fits) begin
            mix_sat = mix_sh[SAMPLE_W-1:0];
        end else if (mix_sh[SUM_W-1]) begin
            mix_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            mix_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    end

    assign ring_we       = s_xfer && (s_op == OP_SAMPLE);
    assign rd_en         = (state_reg == ST_RUN);
    assign mac_ctl.clear = ring_we;
    assign mac_ctl.valid = rd_vld_reg && rd_ok_reg;

    always_comb begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        fill_next      = fill_reg;
        taps_next      = taps_reg;
        j_next         = j_reg;
        bypass_next    = bypass_reg;
        rd_vld_next    = 1'b0;
        rd_ok_next     = rd_ok_reg;
        dry_next       = dry_reg;
        wet_next       = wet_reg;
        pdry_next      = pdry_reg;
        pwet_next      = pwet_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        tap_count_next = tap_count_reg;
        wet_mix_next   = wet_mix_reg;

        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_TAP_COUNT: tap_count_next = cfg_data[TAP_COUNT_W-1:0];
                REG_WET_MIX:   wet_mix_next   = cfg_data[MIX_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (ring_we) begin
                    // store the sample, start reading backwards from it
                    rp_next   = wp_reg;
                    wp_next   = (wp_reg == RING_LAST) ? '0 : wp_reg + RING_AW'(1);
                    fill_next = (fill_reg == FILL_FULL) ? fill_reg : fill_reg + FILL_W'(1);
                    taps_next = taps_eff;
                    j_next    = '0;
                    dry_next  = s_sample_in;
                    if (taps_eff == '0) begin
                        bypass_next = 1'b1;
                        state_next  = ST_OUT;
                    end else begin
                        bypass_next = 1'b0;
                        state_next  = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                // issue one tap a cycle; mask history not written since reset
                rd_vld_next = 1'b1;
                rd_ok_next  = (32'(j_reg) < 32'(fill_reg));
                rp_next     = (rp_reg == '0) ? RING_LAST : rp_reg - RING_AW'(1);
                j_next      = j_reg + TAP_COUNT_W'(1);
                if (j_reg == taps_reg - TAP_COUNT_W'(1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!rd_vld_reg && !mac_busy) begin
                    state_next = ST_WET;
                end
            end
            ST_WET: begin
                wet_next   = WET_W'((mac_acc + $signed(ACC_ROUND)) >>> 17);
                state_next = ST_MUL;
            end
            ST_MUL: begin
                pdry_next  = PDRY_W'(dry_reg) * $signed({1'b0, MIX_ONE - mix_eff});
                pwet_next  = PWET_W'(wet_reg) * $signed({1'b0, mix_eff});
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = bypass_reg ? dry_reg : mix_sat;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            fill_reg      <= '0;
            rd_vld_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
            tap_count_reg <= '0;
            wet_mix_reg   <= MIX_ONE;
        end else begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            rd_vld_reg    <= rd_vld_next;
            m_valid_reg   <= m_valid_next;
            tap_count_reg <= tap_count_next;
            wet_mix_reg   <= wet_mix_next;
        end
        rp_reg     <= rp_next;
        taps_reg   <= taps_next;
        j_reg      <= j_next;
        bypass_reg <= bypass_next;
        rd_ok_reg  <= rd_ok_next;
        dry_reg    <= dry_next;
        wet_reg    <= wet_next;
        pdry_reg   <= pdry_next;
        pwet_reg   <= pwet_next;
        m_data_reg <= m_data_next;
    end

    // History ring of past samples
    fcwdm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RING_DEPTH)
    ) u_hist_ram (
        .clk   (aclk),
        .we    (ring_we),
        .waddr (wp_reg),
        .wdata (s_sample_in),
        .re    (rd_en),
        .raddr (rp_reg),
        .rdata (hist_rdata)
    );

    // Coefficient store
    fcwdm_ram #(
        .WIDTH (TAP_W),
        .DEPTH (TAP_DEPTH)
    ) u_tap_ram (
        .clk   (aclk),
        .we    (s_xfer && (s_op == OP_LOAD)),
        .waddr (s_tap_index),
        .wdata (s_tap_value),
        .re    (rd_en),
        .raddr (j_reg[TAP_AW-1:0]),
        .rdata (tap_rdata)
    );

    fcwdm_mac u_mac (
        .clk   (aclk),
        .rst_n (aresetn),
        .ctl   (mac_ctl),
        .smp   (hist_rdata),
        .coef  (tap_rdata),
        .acc   (mac_acc),
        .busy  (mac_busy)
    );

endmodule

// ----- src/fcwdm_checker.sv -----
// Port-level checker for the FIR convolver, attached by bind.
// Depends on fcwdm_pkg and fir_convolution_wet_dry_mix_top_macros.svh.
`include "fir_convolution_wet_dry_mix_top_macros.svh"

module fcwdm_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic                             s_op,
    input logic                             m_valid,
    input logic                             m_ready,
    input fcwdm_pkg::sample_t               m_sample_out
);
    import fcwdm_pkg::*;

    // a stalled result holds
    `FCWDM_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_sample_out), "result changed while stalled")
    // a coefficient load never produces a result and keeps the block ready
    `FCWDM_ASSERT_NEXT(a_load_silent, aclk, aresetn, s_valid && s_ready && (s_op == OP_LOAD) && !m_valid, !m_valid && s_ready, "load transfer produced a result")
    // a sample transfer occupies the sequencer
    `FCWDM_ASSERT_NEXT(a_sample_busy, aclk, aresetn, s_valid && s_ready && (s_op == OP_SAMPLE), !s_ready, "ready after sample transfer")
    // a new result comes out only as the sequencer returns to idle
    `FCWDM_ASSERT_SAME(a_result_idle, aclk, aresetn, $rose(m_valid), s_ready, "result appeared while busy")

endmodule

bind fir_convolution_wet_dry_mix_top fcwdm_checker u_fcwdm_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_op         (s_op),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_sample_out (m_sample_out)
);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for fir_convolution_wet_dry_mix_top (FIR convolver with dry/wet mix).
// Depends on fcwdm_pkg and the RTL under src/; it keeps its own bit-exact shadow of the taps,
// the history ring and the mix, and checks every output sample in order.
module tb;
    import fcwdm_pkg::*;

    localparam int RING_LEN = RING_DEPTH_DEF;
    localparam int RING_AW = $clog2(RING_LEN);
    localparam longint OUT_MAX = 64'sd8388607;
    localparam longint OUT_MIN = -64'sd8388608;
    localparam sample_t SAMPLE_MAX = 24'sh7FFFFF;
    localparam sample_t SAMPLE_MIN = 24'sh800000;
    localparam tap_t TAP_MAX = 18'sh1FFFF;
    localparam tap_t TAP_MIN = 18'sh20000;
    // An index the block does not map; a write to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = CFG_IDX_W'(15);
    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_HOLD = 300;
    // Taps loaded up front; no tap count ever reaches past them.
    localparam int TAP_FILL = 48;
    localparam int PHASE_ITEMS = 10;
    localparam int PHASES = 7;
    localparam longint RUN_LIMIT_NS = 4_000_000;

    // Shadow of the convolver: tap store, history ring, write pointer and both registers.
    class convolver_shadow;
        sample_t ring [RING_LEN];
        tap_t taps [TAP_DEPTH];
        logic [RING_AW-1:0] wr_ptr;
        logic [TAP_COUNT_W-1:0] tap_count;
        logic [MIX_W-1:0] wet_mix;
        sample_t expected_samples [$];
        int mismatches;

        function new();
            foreach (ring[i]) ring[i] = '0;
            foreach (taps[i]) taps[i] = '0;
            wr_ptr = '0;
            tap_count = '0;
            wet_mix = MIX_ONE;
            mismatches = 0;
        endfunction

        function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_TAP_COUNT)
                tap_count = data[TAP_COUNT_W-1:0];
            else if (idx == REG_WET_MIX)
                wet_mix = data[MIX_W-1:0];
        endfunction

        function sample_t convolve_and_mix(sample_t dry);
            longint acc, wet, mixed, mix;
            int n, j;
            logic [RING_AW-1:0] pos;
            ring[wr_ptr] = dry;
            n = (tap_count > TAP_DEPTH) ? TAP_DEPTH : int'(tap_count);
            if (n > RING_LEN)
                n = RING_LEN;
            acc = 0;
            for (j = 0; j < n; j++) begin
                pos = wr_ptr - RING_AW'(j);
                acc += longint'(ring[pos]) * longint'(taps[j]);
            end
            wr_ptr = wr_ptr + 1'b1;
            if (n == 0)
                return dry;
            mix = longint'(wet_mix > MIX_ONE ? MIX_ONE : wet_mix);
            // Round the Q13.40 sum to Q.23, then the mix back down by 16 bits.
            wet = (acc + 65536) >>> 17;
            mixed = longint'(dry) * (65536 - mix) + wet * mix;
            mixed = (mixed + 32768) >>> 16;
            if (mixed > OUT_MAX)
                mixed = OUT_MAX;
            if (mixed < OUT_MIN)
                mixed = OUT_MIN;
            return sample_t'(mixed);
        endfunction

        function void note_item(logic op, sample_t smp, logic [TAP_AW-1:0] idx, tap_t val);
            if (op == OP_LOAD)
                taps[idx] = val;
            else
                expected_samples.push_back(convolve_and_mix(smp));
        endfunction

        function void check_sample(sample_t got);
            sample_t want;
            if (expected_samples.size() == 0) begin
                $display("%0t: output sample %0d with none outstanding", $time, got);
                mismatches++;
            end else begin
                want = expected_samples.pop_front();
                if (want !== got) begin
                    $display("%0t: sample_out expected %0d, actual %0d", $time, want, got);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_op = OP_SAMPLE;
    sample_t s_sample_in = '0;
    logic [TAP_AW-1:0] s_tap_index = '0;
    tap_t s_tap_value = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    sample_t m_sample_out;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_TAP_COUNT;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    convolver_shadow shadow;
    // High while neither side may idle.
    logic calm = 1'b0;
    // The stimulus bumps this to ask the receiver for one long hold-off.
    int hold_requests = 0;
    int holds_granted = 0;
    int hold_left = 0;

    fir_convolution_wet_dry_mix_top #(.RING_DEPTH(RING_LEN)) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_op(s_op),
        .s_sample_in(s_sample_in),
        .s_tap_index(s_tap_index),
        .s_tap_value(s_tap_value),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_sample_out(m_sample_out),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 0;
    end

    // Watch all three channels at the rising edge; each transfer updates or checks the shadow.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                shadow.apply_register(cfg_index, cfg_data);
            if (s_valid && s_ready)
                shadow.note_item(s_op, s_sample_in, s_tap_index, s_tap_value);
            if (m_valid && m_ready)
                shadow.check_sample(m_sample_out);
        end
    end

    // Receiver: grant a pending long hold-off first, else stall at random unless calm.
    always @(negedge aclk) begin
        if (hold_left == 0 && hold_requests != holds_granted) begin
            holds_granted = holds_granted + 1;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else if (!calm && $urandom_range(99) < 15) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Offer one item; an optional gap lowers valid first. Valid stays high after the
    // transfer so that a following call can go on back to back.
    task automatic send_item(input logic op, input sample_t smp,
                             input logic [TAP_AW-1:0] idx, input tap_t val);
        int gap;
        gap = (!calm && $urandom_range(99) < 15) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            @(negedge aclk) s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_op <= op;
        s_sample_in <= smp;
        s_tap_index <= idx;
        s_tap_value <= val;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Unused fields of a sample carry random noise.
    task automatic send_sample(input sample_t smp);
        send_item(OP_SAMPLE, smp, TAP_AW'($urandom), tap_t'($urandom));
    endtask

    task automatic send_load(input logic [TAP_AW-1:0] idx, input tap_t val);
        send_item(OP_LOAD, sample_t'($urandom), idx, val);
    endtask

    // Drop valid, wait for every outstanding sample, then let a load in flight finish.
    task automatic wait_idle();
        @(negedge aclk) s_valid <= 1'b0;
        while (shadow.expected_samples.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Register writes happen only with the block idle.
    task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
        wait_idle();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(data);
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk) cfg_valid <= 1'b0;
    endtask

    function automatic sample_t random_sample();
        case ($urandom_range(15))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            default: return sample_t'($urandom);
        endcase
    endfunction

    initial begin
        int i, k, phase;
        int unsigned mix_val;
        logic [TAP_AW-1:0] idx;
        tap_t val;
        shadow = new();
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        // Tap count is zero after reset: samples pass through untouched.
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample('0);

        // Fill the low taps with small values so that no tap in use is ever read unwritten.
        for (i = 0; i < TAP_FILL; i++)
            send_load(TAP_AW'(i), tap_t'(int'($urandom_range(0, 1023)) - 512));

        // Full-scale taps at both ends of the store, including the last index.
        send_load(TAP_AW'(0), TAP_MAX);
        send_load(TAP_AW'(1), TAP_MIN);
        send_load(TAP_AW'(2), TAP_MIN);
        send_load(TAP_AW'(3), TAP_MIN);
        send_load(TAP_AW'(TAP_DEPTH - 1), TAP_MIN);

        // Four taps fully wet: a run of negative full scale saturates high,
        // then positive full scale saturates low.
        set_register(REG_TAP_COUNT, 4);
        for (i = 0; i < 4; i++)
            send_sample(SAMPLE_MIN);
        for (i = 0; i < 4; i++)
            send_sample(SAMPLE_MAX);

        // Dry only, mix above one (treated as fully wet), and half and half.
        set_register(REG_WET_MIX, 0);
        send_sample(random_sample());
        set_register(REG_WET_MIX, 131071);
        send_sample(random_sample());
        set_register(REG_WET_MIX, 32768);
        // An unmapped index must leave both registers alone.
        set_register(REG_UNMAPPED, 0);
        send_sample(random_sample());

        // Longest impulse response that was loaded, then a single tap.
        set_register(REG_TAP_COUNT, TAP_FILL);
        send_sample(random_sample());
        send_sample(SAMPLE_MIN);
        set_register(REG_TAP_COUNT, 1);
        send_sample(random_sample());

        // Random phases: new settings each time, then a mix of loads and samples.
        for (phase = 0; phase < PHASES; phase++) begin
            set_register(REG_TAP_COUNT,
                         ($urandom_range(7) == 0) ? 0 : $urandom_range(1, TAP_FILL));
            case ($urandom_range(3))
                0: mix_val = 0;
                1: mix_val = MIX_ONE;
                2: mix_val = $urandom_range(0, 65536);
                default: mix_val = $urandom_range(65537, 131071);
            endcase
            set_register(REG_WET_MIX, mix_val);
            // Hold the receiver off long enough to back the block up into its input.
            if (phase == 1)
                hold_requests = hold_requests + 1;
            calm = (phase == 3);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(3) == 0) begin
                    idx = ($urandom_range(3) != 0) ? TAP_AW'($urandom_range(0, 63))
                                                  : TAP_AW'($urandom);
                    val = ($urandom_range(1) != 0) ? tap_t'($urandom)
                                                  : tap_t'(int'($urandom_range(0, 8191)) - 4096);
                    send_load(idx, val);
                end else begin
                    send_sample(random_sample());
                end
                // Pause the sender mid-phase until every result is back.
                if (phase == 5 && k == PHASE_ITEMS / 2)
                    wait_idle();
            end
        end
        calm = 1'b0;

        wait_idle();
        if (shadow.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Catch a hung handshake.
    initial begin
        #(RUN_LIMIT_NS);
        $display("TB_ERROR");
        $finish;
    end
endmodule
